FILE: hw/rtl/sobel_pkg.sv
`default_nettype none
package sobel_pkg;

  // Configuration register indexes.
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam int unsigned CFG_W    = 11;
  localparam int unsigned PIX_W    = 24;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned GRAD_W   = 12;
  localparam int unsigned SQSUM_W  = 22;
  localparam logic [SQSUM_W-1:0] SAT_LIMIT = 22'd65280;
  localparam logic [CHAN_W-1:0]  SAT_VALUE = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAP,
    ST_DRAIN,
    ST_SQ,
    ST_ROOT,
    ST_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       wr_en;
    logic       clear;
    logic       rd_en;
    logic       rd_ok;
    logic [1:0] tap_r;
    logic [1:0] tap_c;
    logic       square;
    logic       root_step;
    logic [2:0] root_bit;
    logic       load_out;
    logic       frame_end;
  } dp_cmd_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sobel_dp.sv
`default_nettype none
module sobel_dp
  import sobel_pkg::*;
#(
  parameter int unsigned ADDR_W = 12
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dp_cmd_t             cmd,
  input  wire logic [ADDR_W-1:0]   wr_addr,
  input  wire logic [ADDR_W-1:0]   rd_addr,
  input  wire logic [PIX_W-1:0]    wr_data,
  output logic                     out_full,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [PIX_W-1:0]         out_data,
  output logic                     out_last
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data_r;
  logic             tap_pend_r;
  logic             tap_ok_r;
  logic [1:0]       tap_r_r;
  logic [1:0]       tap_c_r;

  logic signed [GRAD_W-1:0] gx_r [3];
  logic signed [GRAD_W-1:0] gx_nxt [3];
  logic signed [GRAD_W-1:0] gy_r [3];
  logic signed [GRAD_W-1:0] gy_nxt [3];
  logic [SQSUM_W-1:0]       s_r [3];
  logic [CHAN_W-1:0]        n_r [3];
  logic [CHAN_W-1:0]        n_nxt [3];
  logic [CHAN_W-1:0]        res [3];

  logic             out_valid_r;
  logic [PIX_W-1:0] out_data_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_pend_r <= 1'b0;
    end else begin
      tap_pend_r <= cmd.rd_en;
    end
    tap_ok_r <= cmd.rd_ok;
    tap_r_r  <= cmd.tap_r;
    tap_c_r  <= cmd.tap_c;
  end

  // Kernel weights are +-1 or +-2, so each tap is a shifted add or subtract.
  always_comb begin
    logic signed [GRAD_W-1:0] pix;
    logic signed [GRAD_W-1:0] tx;
    logic signed [GRAD_W-1:0] ty;
    for (int ch = 0; ch < 3; ch++) begin
      pix = tap_ok_r ? GRAD_W'(rd_data_r[ch*CHAN_W +: CHAN_W]) : '0;
      tx  = (tap_r_r == 2'd1) ? (pix <<< 1) : pix;
      ty  = (tap_c_r == 2'd1) ? (pix <<< 1) : pix;
      gx_nxt[ch] = gx_r[ch];
      gy_nxt[ch] = gy_r[ch];
      if (tap_pend_r) begin
        if (tap_c_r == 2'd0) gx_nxt[ch] = gx_r[ch] - tx;
        else if (tap_c_r == 2'd2) gx_nxt[ch] = gx_r[ch] + tx;
        if (tap_r_r == 2'd0) gy_nxt[ch] = gy_r[ch] - ty;
        else if (tap_r_r == 2'd2) gy_nxt[ch] = gy_r[ch] + ty;
      end
    end
  end

  // One result bit per step for all three channels.
  always_comb begin
    logic [CHAN_W-1:0]   t;
    logic [2*CHAN_W-1:0] tt;
    for (int ch = 0; ch < 3; ch++) begin
      t  = n_r[ch] | (CHAN_W'(1) << cmd.root_bit);
      tt = t * t;
      n_nxt[ch] = (SQSUM_W'(tt) <= s_r[ch]) ? t : n_r[ch];
    end
  end

  always_comb begin
    logic [2*CHAN_W:0] lim;
    for (int ch = 0; ch < 3; ch++) begin
      lim = (2*CHAN_W+1)'(n_r[ch] * n_r[ch]) + (2*CHAN_W+1)'(n_r[ch]);
      if (s_r[ch] > SAT_LIMIT) res[ch] = SAT_VALUE;
      else if (s_r[ch] > SQSUM_W'(lim)) res[ch] = n_r[ch] + 8'd1;
      else res[ch] = n_r[ch];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [2*GRAD_W-1:0] sqx;
    logic signed [2*GRAD_W-1:0] sqy;
    for (int ch = 0; ch < 3; ch++) begin
      sqx = gx_r[ch] * gx_r[ch];
      sqy = gy_r[ch] * gy_r[ch];
      if (cmd.clear) begin
        gx_r[ch] <= '0;
        gy_r[ch] <= '0;
      end else begin
        gx_r[ch] <= gx_nxt[ch];
        gy_r[ch] <= gy_nxt[ch];
      end
      if (cmd.square) begin
        s_r[ch] <= SQSUM_W'(sqx) + SQSUM_W'(sqy);
        n_r[ch] <= '0;
      end else if (cmd.root_step) begin
        n_r[ch] <= n_nxt[ch];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.load_out) begin
      out_data_r <= {res[2], res[1], res[0]};
      out_last_r <= cmd.frame_end;
    end
  end

  assign out_full  = out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

FILE: hw/rtl/sobel_ctrl.sv
`default_nettype none
module sobel_ctrl
  import sobel_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned ADDR_W     = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  input  wire logic                 in_mode,
  output logic                      in_ready,
  input  wire logic                 out_full,
  output dp_cmd_t                   cmd,
  output logic [ADDR_W-1:0]         wr_addr,
  output logic [ADDR_W-1:0]         rd_addr
);

  localparam int unsigned CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW     = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW     = $clog2(MAX_HEIGHT + 1);

  logic [CFG_W-1:0] width_cfg_r;
  logic [CFG_W-1:0] height_cfg_r;
  logic [WW-1:0]    w_eff;
  logic [RW-1:0]    h_eff;

  state_t        state_r, state_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [RW-1:0] out_row_r, out_row_nxt;
  logic [1:0]    tr_r, tr_nxt;
  logic [1:0]    tc_r, tc_nxt;
  logic [2:0]    bit_r, bit_nxt;

  logic          in_fire;
  logic          frame_full;
  logic          in_col_end;
  logic          out_col_end;
  logic          out_row_last;
  logic [RW-1:0] tap_row;
  logic [CW-1:0] tap_col;
  logic          row_ok;
  logic          col_ok;

  always_comb begin
    if (width_cfg_r == '0) w_eff = WW'(1);
    else if (32'(width_cfg_r) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(width_cfg_r);
    if (height_cfg_r == '0) h_eff = RW'(1);
    else if (32'(height_cfg_r) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
    else h_eff = RW'(height_cfg_r);
  end

  assign in_ready     = (state_r == ST_IDLE);
  assign in_fire      = in_valid && in_ready;
  assign frame_full   = (in_row_r >= h_eff);
  assign in_col_end   = (WW'(in_col_r) + WW'(1) >= w_eff);
  assign out_col_end  = (WW'(out_col_r) + WW'(1) >= w_eff);
  assign out_row_last = ((RW+1)'(out_row_r) + (RW+1)'(1) >= (RW+1)'(h_eff));

  // Neighbor position of the current tap, with a flag for inside the image.
  always_comb begin
    unique case (tr_r)
      2'd0: begin
        tap_row = out_row_r - RW'(1);
        row_ok  = (out_row_r != '0);
      end
      2'd1: begin
        tap_row = out_row_r;
        row_ok  = 1'b1;
      end
      default: begin
        tap_row = out_row_r + RW'(1);
        row_ok  = !out_row_last;
      end
    endcase
    unique case (tc_r)
      2'd0: begin
        tap_col = out_col_r - CW'(1);
        col_ok  = (out_col_r != '0);
      end
      2'd1: begin
        tap_col = out_col_r;
        col_ok  = 1'b1;
      end
      default: begin
        tap_col = out_col_r + CW'(1);
        col_ok  = !out_col_end;
      end
    endcase
  end

  assign wr_addr = {in_row_r[1:0], in_col_r};
  assign rd_addr = {tap_row[1:0], tap_col};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= CFG_W'(1024);
      height_cfg_r <= CFG_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_cfg_r  <= cfg_data;
        REG_IMAGE_HEIGHT: height_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      tr_r      <= '0;
      tc_r      <= '0;
      bit_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      tr_r      <= tr_nxt;
      tc_r      <= tc_nxt;
      bit_r     <= bit_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    tr_nxt      = tr_r;
    tc_nxt      = tc_r;
    bit_nxt     = bit_r;
    cmd         = '0;
    cmd.tap_r   = tr_r;
    cmd.tap_c   = tc_r;
    cmd.root_bit = bit_r;
    cmd.rd_ok   = row_ok && col_ok;

    unique case (state_r)
      ST_IDLE: begin
        tr_nxt = '0;
        tc_nxt = '0;
        if (cfg_we) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (in_fire && !in_mode) begin
          if (!frame_full) begin
            cmd.wr_en = 1'b1;
            if (in_col_end) begin
              in_col_nxt = '0;
              in_row_nxt = in_row_r + RW'(1);
            end else begin
              in_col_nxt = in_col_r + CW'(1);
            end
            if ((in_row_r >= RW'(2)) || ((in_row_r == RW'(1)) && (in_col_r != '0))) begin
              cmd.clear = 1'b1;
              state_nxt = ST_TAP;
            end
          end
        end else if (in_fire && in_mode) begin
          if (frame_full) begin
            if (out_row_r >= h_eff) begin
              in_col_nxt  = '0;
              in_row_nxt  = '0;
              out_col_nxt = '0;
              out_row_nxt = '0;
            end else begin
              cmd.clear = 1'b1;
              state_nxt = ST_TAP;
            end
          end
        end
      end
      ST_TAP: begin
        cmd.rd_en = 1'b1;
        if (tc_r == 2'd2) begin
          tc_nxt = '0;
          tr_nxt = tr_r + 2'd1;
          if (tr_r == 2'd2) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          tc_nxt = tc_r + 2'd1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.square = 1'b1;
        bit_nxt    = 3'd7;
        state_nxt  = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        bit_nxt       = bit_r - 3'd1;
        if (bit_r == 3'd0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_full) begin
          cmd.load_out  = 1'b1;
          cmd.frame_end = out_col_end && out_row_last;
          state_nxt     = ST_IDLE;
          if (out_col_end && out_row_last) begin
            in_col_nxt  = '0;
            in_row_nxt  = '0;
            out_col_nxt = '0;
            out_row_nxt = '0;
          end else if (out_col_end) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + RW'(1);
          end else begin
            out_col_nxt = out_col_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sobel_edge_rgb_stream_top.sv
`default_nettype none
// Streaming 3x3 Sobel edge detector for RGB pixels in raster order. Each pixel
// beat of the frame writes the pixel into a four-row line store; once enough of
// the frame is in (width+1 pixels), each pixel beat also yields the result for
// the pixel width+1 places earlier, and after the frame's last pixel flush beats
// (in_tuser high) drain the remaining results, the last one marked by tlast.
// Each channel gives round(sqrt(gx^2+gy^2)) saturated to 255, with neighbors
// outside the image taken as zero. A beat with no result leaves the input ready.
// A beat with a result runs the nine neighborhood reads through the single
// line-store read port, a drain and a squaring step, the bit-serial square
// root and a final step that rounds and loads the output register once it is
// free. The output register lets the next beat enter while a result waits.
// Writing image_width or image_height while idle restarts the frame.
module sobel_edge_rgb_stream_top
  import sobel_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Configuration: index 0 is image_width, index 1 is image_height.
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [PIX_W-1:0]  in_tdata,   // blue [7:0], green [15:8], red [23:16]
  input  wire logic              in_tuser,   // mode: 0 pixel, 1 flush
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [PIX_W-1:0]       out_tdata,  // edge_blue, edge_green, edge_red
  output logic                   out_tlast   // frame_end
);

  localparam int unsigned CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned ADDR_W = CW + 2;

  dp_cmd_t           cmd;
  logic              out_full;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  sobel_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_mode   (in_tuser),
    .in_ready  (in_tready),
    .out_full  (out_full),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr)
  );

  sobel_dp #(
    .ADDR_W (ADDR_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .wr_data   (in_tdata),
    .out_full  (out_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
`default_nettype none
module tb_top;
  import sobel_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_W     = 1024;
  localparam int unsigned MAX_H     = 1024;
  localparam int unsigned RING      = 2 * MAX_W + 3;
  // Settling time that covers any beat that is still being worked on when
  // the queue has gone empty.
  localparam int unsigned SETTLE    = 60;

  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] px;   // blue [7:0], green [15:8], red [23:16]
  } edge_res_t;

  typedef enum logic [1:0] {ROW_WIDTH, ROW_HEIGHT, ROW_PIXEL, ROW_FLUSH} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [PIX_W-1:0] val;    // register value or pixel
    logic             typed;  // expected result written out in the table
    edge_res_t        res;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             in_tvalid;
  logic             in_tready;
  logic [PIX_W-1:0] in_tdata;   // blue [7:0], green [15:8], red [23:16]
  logic             in_tuser;   // mode: 0 pixel, 1 flush
  logic             out_tvalid;
  logic             out_tready;
  logic [PIX_W-1:0] out_tdata;  // edge_blue [7:0], edge_green [15:8], edge_red [23:16]
  logic             out_tlast;  // frame_end

  sobel_edge_rgb_stream_top #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  // Mirror of the block's state, kept by the edge predictor below.
  logic [PIX_W-1:0] pix_history [RING];
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int unsigned      next_col;
  int unsigned      next_row;
  int unsigned      next_result;

  edge_res_t   pending_edges[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned beats_sent;
  bit          stim_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Effective sizes: zero acts as one, anything above the maximum is clamped.
  function automatic int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned max_v);
    if (v == 0) return 1;
    if (v > max_v) return max_v;
    return v;
  endfunction

  // Rounded integer square root with saturation at 255.
  function automatic logic [7:0] rounded_root(int unsigned s);
    int unsigned n;
    int unsigned t;
    n = 0;
    if (s > 65280) return 8'hFF;
    for (int b = 7; b >= 0; b--) begin
      t = n | (1 << b);
      if (t * t <= s) n = t;
    end
    if (s > n * n + n) n++;
    return n[7:0];
  endfunction

  // Sobel magnitude of the three channels for the pixel at linear index q.
  function automatic logic [PIX_W-1:0] sobel_at(int unsigned q);
    int unsigned w;
    int unsigned h;
    int          ro;
    int          co;
    int          r;
    int          c;
    int          gx;
    int          gy;
    int          p;
    logic [PIX_W-1:0] v;
    logic [PIX_W-1:0] mag;
    w  = eff_size(width_reg, MAX_W);
    h  = eff_size(height_reg, MAX_H);
    ro = q / w;
    co = q % w;
    for (int ch = 0; ch < 3; ch++) begin
      gx = 0;
      gy = 0;
      for (int dr = 0; dr < 3; dr++) begin
        for (int dc = 0; dc < 3; dc++) begin
          r = ro + dr - 1;
          c = co + dc - 1;
          v = '0;
          if (r >= 0 && r < int'(h) && c >= 0 && c < int'(w))
            v = pix_history[(r * w + c) % RING];
          p = v[8*ch +: 8];
          // Center row and center column carry weight two.
          gx += (dc - 1) * ((dr == 1) ? 2 : 1) * p;
          gy += (dr - 1) * ((dc == 1) ? 2 : 1) * p;
        end
      end
      mag[8*ch +: 8] = rounded_root(gx * gx + gy * gy);
    end
    return mag;
  endfunction

  function automatic void restart_frame();
    next_col    = 0;
    next_row    = 0;
    next_result = 0;
  endfunction

  // Advances the mirrored state by one accepted beat; got says whether a
  // result comes out of it.
  function automatic void edge_predict(input logic mode, input logic [PIX_W-1:0] pix,
                                       output bit got, output edge_res_t res);
    int unsigned w;
    int unsigned h;
    int unsigned p;
    w   = eff_size(width_reg, MAX_W);
    h   = eff_size(height_reg, MAX_H);
    got = 0;
    res = '0;
    if (mode == 1'b0) begin
      if (next_row >= h) return;
      p = next_row * w + next_col;
      pix_history[p % RING] = pix;
      next_col++;
      if (next_col >= w) begin
        next_col = 0;
        next_row++;
      end
      if (p < w + 1) return;
      res.px = sobel_at(next_result);
      next_result++;
      got = 1;
    end else begin
      if (next_row < h) return;
      if (next_result >= w * h) begin
        restart_frame();
        return;
      end
      res.px = sobel_at(next_result);
      next_result++;
      got = 1;
      if (next_result >= w * h) begin
        res.last = 1'b1;
        restart_frame();
      end
    end
  endfunction

  // Random gap length: mostly none or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Channel bytes lean toward the extremes so that saturation is reached.
  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [PIX_W-1:0] px;
    for (int ch = 0; ch < 3; ch++) begin
      case ($urandom_range(9))
        0: px[8*ch +: 8] = 8'h00;
        1, 2: px[8*ch +: 8] = 8'hFF;
        default: px[8*ch +: 8] = 8'($urandom_range(255));
      endcase
    end
    return px;
  endfunction

  // Register writes happen only with the block idle: every expected result
  // is in and the block has had time to finish any beat without a result.
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    in_tvalid = 1'b0;
    @(negedge clk);
    while (pending_edges.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
    restart_frame();
  endtask

  // Offers one beat, starting at a falling edge, and returns at the falling
  // edge after it was accepted with tvalid still high; the next call or the
  // end of stimulus decides whether it drops.
  task automatic send_beat(input logic mode, input logic [PIX_W-1:0] pix,
                           input bit typed, input edge_res_t typed_res);
    int unsigned gap;
    bit          got;
    edge_res_t   res;
    gap = gap_len();
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = pix;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    edge_predict(mode, pix, got, res);
    if (typed) pending_edges.push_back(typed_res);
    else if (got) pending_edges.push_back(res);
    @(negedge clk);
  endtask

  task automatic pixel(input logic [PIX_W-1:0] px);
    send_beat(1'b0, px, 1'b0, '0);
  endtask

  task automatic flush();
    send_beat(1'b1, PIX_W'($urandom), 1'b0, '0);
  endtask

  // Directed table: tiny frames, register extremes, ignored beats and the
  // short-frame case where every result comes from a flush.
  stim_row_t dir_rows [28];

  initial begin
    dir_rows = '{
      // One-pixel frame: the pixel gives nothing, the flush gives a flat zero.
      '{ROW_WIDTH,  24'd1,      1'b0, '0},
      '{ROW_HEIGHT, 24'd1,      1'b0, '0},
      '{ROW_PIXEL,  24'hFFFFFF, 1'b0, '0},
      '{ROW_PIXEL,  24'h123456, 1'b0, '0},   // frame already full: ignored
      '{ROW_FLUSH,  24'h0,      1'b1, '{1'b1, 24'h000000}},
      '{ROW_FLUSH,  24'h0,      1'b0, '0},   // new frame not filled: ignored
      // 3x3 frame of black, white and colored pixels.
      '{ROW_WIDTH,  24'd3,      1'b0, '0},
      '{ROW_HEIGHT, 24'd3,      1'b0, '0},
      '{ROW_PIXEL,  24'hFFFFFF, 1'b0, '0},
      '{ROW_FLUSH,  24'h0,      1'b0, '0},   // flush before the frame is full
      '{ROW_PIXEL,  24'h000000, 1'b0, '0},
      '{ROW_PIXEL,  24'hFFFFFF, 1'b0, '0},
      '{ROW_PIXEL,  24'h000000, 1'b0, '0},
      '{ROW_PIXEL,  24'hFF00FF, 1'b0, '0},
      '{ROW_PIXEL,  24'h00FF00, 1'b0, '0},
      '{ROW_PIXEL,  24'hFFFFFF, 1'b0, '0},
      '{ROW_PIXEL,  24'h0000FF, 1'b0, '0},
      '{ROW_PIXEL,  24'hFF0000, 1'b0, '0},
      '{ROW_FLUSH,  24'h0,      1'b0, '0},
      '{ROW_FLUSH,  24'h0,      1'b0, '0},
      '{ROW_FLUSH,  24'h0,      1'b0, '0},
      '{ROW_FLUSH,  24'h0,      1'b0, '0},
      // Width zero acts as one; a black pixel over a white one saturates.
      '{ROW_WIDTH,  24'd0,      1'b0, '0},
      '{ROW_HEIGHT, 24'd2,      1'b0, '0},
      '{ROW_PIXEL,  24'h000000, 1'b0, '0},
      '{ROW_PIXEL,  24'hFFFFFF, 1'b0, '0},
      '{ROW_FLUSH,  24'h0,      1'b1, '{1'b0, 24'hFFFFFF}},
      '{ROW_FLUSH,  24'h0,      1'b1, '{1'b1, 24'h000000}}
    };
  end

  // One frame with random content. Now and then a stray flush lands inside
  // the frame, a stray pixel after it, or the frame is cut short.
  task automatic run_frame(input int unsigned w, input int unsigned h, output bit cut);
    int unsigned total;
    int unsigned stop_at;
    total   = w * h;
    cut     = ($urandom_range(19) == 0) && total > 1;
    stop_at = cut ? $urandom_range(1, total - 1) : total;
    for (int unsigned i = 0; i < stop_at; i++) begin
      if ($urandom_range(39) == 0) flush();
      pixel(rand_pixel());
    end
    if (cut) return;
    if ($urandom_range(3) == 0) pixel(rand_pixel());
    for (int unsigned i = 0; i < ((total < w + 1) ? total : w + 1); i++) flush();
    if ($urandom_range(4) == 0) flush();
  endtask

  // Stimulus driver.
  initial begin
    int unsigned phase;
    int unsigned w;
    int unsigned h;
    logic [CFG_W-1:0] wv;
    logic [CFG_W-1:0] hv;
    bit cut;
    cfg_we     = 1'b0;
    cfg_index  = REG_IMAGE_WIDTH;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    stim_done  = 0;
    beats_sent = 0;
    width_reg  = CFG_W'(MAX_W);
    height_reg = CFG_W'(MAX_H);
    restart_frame();
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_WIDTH:  write_reg(REG_IMAGE_WIDTH, dir_rows[i].val[CFG_W-1:0]);
        ROW_HEIGHT: write_reg(REG_IMAGE_HEIGHT, dir_rows[i].val[CFG_W-1:0]);
        ROW_PIXEL:  send_beat(1'b0, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].res);
        default:    send_beat(1'b1, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].res);
      endcase
    end

    // Random phases. The first writes out-of-range values to both registers,
    // which clamp to the largest frame, and sends only the start of its first
    // row, which yields no results; the rest use small frames.
    phase = 0;
    while (beats_sent < 700) begin
      case (phase)
        0: begin
          wv = 11'h7FF;
          hv = 11'h7FF;
        end
        default: begin
          wv = ($urandom_range(9) == 0) ? 11'd0 : CFG_W'($urandom_range(1, 7));
          hv = ($urandom_range(9) == 0) ? 11'd0 : CFG_W'($urandom_range(1, 5));
        end
      endcase
      if ($urandom_range(1) != 0) begin
        write_reg(REG_IMAGE_WIDTH, wv);
        write_reg(REG_IMAGE_HEIGHT, hv);
      end else begin
        write_reg(REG_IMAGE_HEIGHT, hv);
        write_reg(REG_IMAGE_WIDTH, wv);
      end
      w = eff_size(wv, MAX_W);
      h = eff_size(hv, MAX_H);
      if (phase == 0) begin
        repeat (50) pixel(rand_pixel());
      end else begin
        for (int f = $urandom_range(1, 3); f > 0; f--) begin
          run_frame(w, h, cut);
          if (cut) break;
        end
      end
      phase++;
    end
    in_tvalid = 1'b0;
    stim_done = 1;
  end

  // Result sink: random stalls, plus one long hold-off once the stream is
  // running so that the output register fills and the input stalls.
  initial begin
    int unsigned stall;
    bit          held;
    held       = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 40) begin
        held       = 1;
        out_tready = 1'b0;
        repeat (400) @(negedge clk);
      end
      stall = gap_len();
      if (stall != 0) begin
        out_tready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Result checker, sampling at the rising edge.
  initial begin
    edge_res_t want;
    mismatches   = 0;
    results_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        results_seen++;
        if (pending_edges.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result data=%h last=%b", $realtime, out_tdata,
                     out_tlast);
        end else begin
          want = pending_edges.pop_front();
          if (out_tdata[7:0] !== want.px[7:0] || out_tdata[15:8] !== want.px[15:8] ||
              out_tdata[23:16] !== want.px[23:16] || out_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result %0d expected data=%h last=%b, got data=%h last=%b",
                       $realtime, results_seen, want.px, want.last, out_tdata, out_tlast);
          end
        end
      end
    end
  end

  // End of run: drain, settle, report.
  initial begin
    wait (stim_done);
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pending_edges.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire
